// File: hdl/mfe_pkg.sv
// Shared types and constants for the message frame escape encoder.
package mfe_pkg;

    localparam int SEQ_W = 14;
    localparam logic [SEQ_W-1:0] SEQ_WRAP = 14'd10000;

    localparam logic [7:0] ESC_FLAG     = 8'h7E;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
    localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
    localparam logic [7:0] FLAG_RESET   = 8'h7E;

    // input kind codes
    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_BODY  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PHONE_BCD  = 2'd0;
    localparam logic [1:0] REG_PHONE_SET  = 2'd1;
    localparam logic [1:0] REG_FRAME_FLAG = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // open frame: flag, 12 header bytes
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] OPEN_LAST_IDX  = 4'd12;
    localparam logic [IDX_W-1:0] CLOSE_LAST_IDX = 4'd1;

    typedef enum logic [1:0] {
        OP_OPEN,
        OP_BODY,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [15:0]      msg_id;
        logic [15:0]      msg_props;
        logic [7:0]       data;     // body byte, or checksum on close
        logic [SEQ_W-1:0] seq;
    } job_t;

    typedef struct packed {
        logic [47:0] phone_bcd;
        logic        phone_set;
        logic [7:0]  frame_flag;
    } cfg_t;

endpackage

// File: hdl/mfe_ifs.sv
// Channel interfaces: input items, output bytes and configuration writes.
interface mfe_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] msg_id;
    logic [15:0] msg_props;
    logic [7:0]  body_byte;

    modport source (output valid, kind, msg_id, msg_props, body_byte, input ready);
    modport sink (input valid, kind, msg_id, msg_props, body_byte, output ready);
endinterface

interface mfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

interface mfe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/message_frame_escape_encoder.sv
// Message frame escape encoder: top level with configuration registers.
//
// Channels: "item" takes open / body / close items, "frame" returns the escaped
// frame one byte per transaction with last set on the final byte of each item,
// "cfg" writes phone_bcd (0), phone_set (1) and frame_flag (2); cfg is always
// ready and indexes beyond the list are ignored.
// The front end accepts one item per cycle while its four-entry job queue has
// room; items that make no output (no phone number, body or close outside a
// frame, unused kind) are taken and dropped there.
// The back end sends one byte per cycle while the receiver is ready: an open item
// makes 13 to 25 bytes, a body item 1 or 2, a close item 2 or 3. That byte rate of
// the output register sets the sustained throughput.
// An accepted item passes through a queue slot and the job register to the output
// register on its way to the frame channel.
// Reset clears the sequence number, checksum, frame state, queue and output valid
// flag, sets frame_flag to 0x7E and clears the phone configuration.
// When the receiver stalls, the output byte holds, the back end waits and the
// queue fills; item.ready drops only once the queue is full.
module message_frame_escape_encoder
    import mfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mfe_item_if.sink   item,
    mfe_byte_if.source frame,
    mfe_cfg_if.sink    cfg
);

    cfg_t cfg_reg;
    logic q_push, q_pop, q_full, q_not_empty;
    job_t q_push_job, q_head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phone_bcd  <= '0;
            cfg_reg.phone_set  <= 1'b0;
            cfg_reg.frame_flag <= FLAG_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PHONE_BCD:  cfg_reg.phone_bcd  <= cfg.data;
                REG_PHONE_SET:  cfg_reg.phone_set  <= cfg.data[0];
                REG_FRAME_FLAG: cfg_reg.frame_flag <= cfg.data[7:0];
                default:        cfg_reg.phone_set  <= cfg_reg.phone_set;
            endcase
        end
    end

    mfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (q_push),
        .push_job (q_push_job)
    );

    mfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (q_pop)
    );

endmodule

// File: hdl/mfe_front.sv
// Front end: accepts items, tracks frame state, sequence and checksum, issues jobs.
module mfe_front
    import mfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mfe_item_if.sink   item,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [7:0]       xor_reg, xor_next;
    logic             in_frame_reg, in_frame_next;
    logic             accept;
    logic [7:0]       hdr_xor;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        hdr_xor = item.msg_id[15:8] ^ item.msg_id[7:0]
                ^ item.msg_props[15:8] ^ item.msg_props[7:0]
                ^ cfg.phone_bcd[47:40] ^ cfg.phone_bcd[39:32] ^ cfg.phone_bcd[31:24]
                ^ cfg.phone_bcd[23:16] ^ cfg.phone_bcd[15:8] ^ cfg.phone_bcd[7:0]
                ^ {2'b00, seq_reg[13:8]} ^ seq_reg[7:0];
    end

    always_comb
    begin
        seq_next           = seq_reg;
        xor_next           = xor_reg;
        in_frame_next      = in_frame_reg;
        push               = 1'b0;
        push_job.op        = OP_BODY;
        push_job.msg_id    = item.msg_id;
        push_job.msg_props = item.msg_props;
        push_job.data      = item.body_byte;
        push_job.seq       = seq_reg;
        if (accept && cfg.phone_set)
        begin
            case (item.kind)
                KIND_OPEN:
                begin
                    push          = 1'b1;
                    push_job.op   = OP_OPEN;
                    xor_next      = hdr_xor;
                    in_frame_next = 1'b1;
                end
                KIND_BODY:
                begin
                    if (in_frame_reg)
                    begin
                        push     = 1'b1;
                        xor_next = xor_reg ^ item.body_byte;
                    end
                end
                KIND_CLOSE:
                begin
                    if (in_frame_reg)
                    begin
                        push          = 1'b1;
                        push_job.op   = OP_CLOSE;
                        push_job.data = xor_reg;
                        in_frame_next = 1'b0;
                        seq_next      = (seq_reg >= SEQ_WRAP) ? '0 : seq_reg + 1'b1;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= '0;
            xor_reg      <= '0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            seq_reg      <= seq_next;
            xor_reg      <= xor_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// File: hdl/mfe_queue.sv
// Small job queue between the front and back ends.
module mfe_queue
    import mfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    job_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: hdl/mfe_back.sv
// Back end: walks each job byte by byte, escapes inner bytes, drives the output register.
module mfe_back
    import mfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mfe_byte_if.source frame,
    input  cfg_t       cfg,
    input  logic       q_not_empty,
    input  job_t       q_head,
    output logic       pop
);

    job_t             job_reg;
    logic             job_valid_reg, job_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [7:0]       second_reg, second_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic             out_free, emit, advance, is_final, inner, need_esc;
    logic [7:0]       raw, emit_byte;

    assign frame.valid    = out_valid_reg;
    assign frame.out_byte = out_byte_reg;
    assign frame.last     = out_last_reg;

    // raw byte at the current position and whether it sits between the flags
    always_comb
    begin
        raw      = job_reg.data;
        inner    = 1'b1;
        is_final = 1'b1;
        case (job_reg.op)
            OP_OPEN:
            begin
                inner    = (idx_reg != '0);
                is_final = (idx_reg == OPEN_LAST_IDX);
                case (idx_reg)
                    4'd0:    raw = cfg.frame_flag;
                    4'd1:    raw = job_reg.msg_id[15:8];
                    4'd2:    raw = job_reg.msg_id[7:0];
                    4'd3:    raw = job_reg.msg_props[15:8];
                    4'd4:    raw = job_reg.msg_props[7:0];
                    4'd5:    raw = cfg.phone_bcd[47:40];
                    4'd6:    raw = cfg.phone_bcd[39:32];
                    4'd7:    raw = cfg.phone_bcd[31:24];
                    4'd8:    raw = cfg.phone_bcd[23:16];
                    4'd9:    raw = cfg.phone_bcd[15:8];
                    4'd10:   raw = cfg.phone_bcd[7:0];
                    4'd11:   raw = {2'b00, job_reg.seq[13:8]};
                    default: raw = job_reg.seq[7:0];
                endcase
            end
            OP_CLOSE:
            begin
                inner    = (idx_reg == '0);
                is_final = (idx_reg == CLOSE_LAST_IDX);
                raw      = (idx_reg == '0) ? job_reg.data : cfg.frame_flag;
            end
            default:
            begin
                inner    = 1'b1;
                is_final = 1'b1;
                raw      = job_reg.data;
            end
        endcase
    end

    assign need_esc = inner && ((raw == ESC_FLAG) || (raw == ESC_BYTE));
    assign out_free = !out_valid_reg || frame.ready;
    assign emit     = job_valid_reg && out_free;

    always_comb
    begin
        pend_next   = pend_reg;
        second_next = second_reg;
        if (pend_reg)
        begin
            emit_byte = second_reg;
            advance   = 1'b1;
        end
        else if (need_esc)
        begin
            emit_byte   = ESC_BYTE;
            advance     = 1'b0;
            second_next = (raw == ESC_FLAG) ? ESC_FOR_FLAG : ESC_FOR_ESC;
        end
        else
        begin
            emit_byte = raw;
            advance   = 1'b1;
        end
        if (emit)
            pend_next = !pend_reg && need_esc;
    end

    assign pop = !job_valid_reg || (emit && advance && is_final);

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (emit && advance)
        begin
            if (is_final)
                job_valid_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
        if (pop && q_not_empty)
        begin
            job_valid_next = 1'b1;
            idx_next       = '0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        second_reg <= second_next;
        if (pop && q_not_empty)
            job_reg <= q_head;
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= advance && is_final;
        end
    end

endmodule

// File: bench/tb.sv
// Testbench for the message frame escape encoder: predicts escaped frame bytes and checks them.
module tb
    import mfe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } line_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    mfe_item_if item_ch();
    mfe_byte_if frame_ch();
    mfe_cfg_if  cfg_ch();

    message_frame_escape_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    // predicted block state and configuration
    logic [47:0]      phone     = '0;
    logic             phone_ok  = 1'b0;
    logic [7:0]       flag_byte = FLAG_RESET;
    logic [SEQ_W-1:0] seq_nr    = '0;
    logic [7:0]       chk       = '0;
    logic             in_frame  = 1'b0;

    line_byte_t line_q[$];
    int errors = 0;
    int cycles = 0;
    int items_sent = 0;

    int         rx_mode = 0;
    int         hold_cycles = 0;
    logic [7:0] stall_pat = 8'hFF;
    bit         gaps_on = 1'b0;
    int         burst_left = 0;

    function automatic void push_raw(logic [7:0] b);
        line_q.push_back('{b, 1'b0});
    endfunction

    function automatic void push_escaped(logic [7:0] b);
        if (b == ESC_FLAG)
        begin
            push_raw(ESC_BYTE);
            push_raw(ESC_FOR_FLAG);
        end
        else if (b == ESC_BYTE)
        begin
            push_raw(ESC_BYTE);
            push_raw(ESC_FOR_ESC);
        end
        else
            push_raw(b);
    endfunction

    function automatic void push_inner(logic [7:0] b);
        chk = chk ^ b;
        push_escaped(b);
    endfunction

    function automatic void predict_line_bytes(logic [1:0] kind, logic [15:0] id,
                                               logic [15:0] props, logic [7:0] body);
        int n0;
        n0 = line_q.size();
        if (!phone_ok)
            return;
        case (kind)
            KIND_OPEN:
            begin
                chk = '0;
                in_frame = 1'b1;
                push_raw(flag_byte);
                push_inner(id[15:8]);
                push_inner(id[7:0]);
                push_inner(props[15:8]);
                push_inner(props[7:0]);
                for (int i = 5; i >= 0; i--)
                    push_inner(phone[8*i +: 8]);
                push_inner({2'b00, seq_nr[13:8]});
                push_inner(seq_nr[7:0]);
            end
            KIND_BODY:
                if (in_frame)
                    push_inner(body);
            KIND_CLOSE:
                if (in_frame)
                begin
                    push_escaped(chk);
                    push_raw(flag_byte);
                    in_frame = 1'b0;
                    seq_nr = (seq_nr >= SEQ_WRAP) ? '0 : seq_nr + 1'b1;
                end
            default: ;
        endcase
        if (line_q.size() > n0)
            line_q[line_q.size()-1].last = 1'b1;
    endfunction

    // all transactions are observed here at the rising edge
    always @(posedge clk)
    begin
        line_byte_t want;
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (line_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: byte with none expected: actual %h last %b",
                             $time, frame_ch.out_byte, frame_ch.last);
                end
                else
                begin
                    want = line_q.pop_front();
                    if (frame_ch.out_byte !== want.value)
                    begin
                        errors++;
                        $display("%0t: out_byte mismatch: expected %h actual %h",
                                 $time, want.value, frame_ch.out_byte);
                    end
                    if (frame_ch.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: last mismatch: expected %b actual %b",
                                 $time, want.last, frame_ch.last);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_PHONE_BCD:  phone = cfg_ch.data;
                    REG_PHONE_SET:  phone_ok = cfg_ch.data[0];
                    REG_FRAME_FLAG: flag_byte = cfg_ch.data[7:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready)
                predict_line_bytes(item_ch.kind, item_ch.msg_id, item_ch.msg_props,
                                   item_ch.body_byte);
        end
    end

    // receiver: long hold-off when requested, otherwise the current stall pattern
    initial
    begin
        int k;
        k = 0;
        frame_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            k++;
            if (hold_cycles > 0)
            begin
                frame_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                case (rx_mode)
                    0:       frame_ch.ready <= 1'b1;
                    1:       frame_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       frame_ch.ready <= 1'($urandom_range(0, 1));
                    default: frame_ch.ready <= stall_pat[k % 8];
                endcase
        end
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? ESC_FLAG : ESC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_word();
        return {rand_byte(), rand_byte()};
    endfunction

    task automatic idle_input(int n);
        @(negedge clk);
        item_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // fold: the body byte is XORed with the running checksum, steering it to a chosen value
    task automatic send_item(logic [1:0] kind, logic [15:0] id, logic [15:0] props,
                             logic [7:0] body, bit fold = 1'b0);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                idle_input($urandom_range(1, 6));
            end
            burst_left--;
        end
        @(negedge clk);
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= kind;
        item_ch.msg_id    <= id;
        item_ch.msg_props <= props;
        item_ch.body_byte <= fold ? (body ^ chk) : body;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (line_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(logic [47:0] ph, logic set, logic [7:0] fl);
        wait_drained();
        write_reg(REG_PHONE_BCD, ph);
        write_reg(REG_PHONE_SET, {47'b0, set});
        write_reg(REG_FRAME_FLAG, {40'b0, fl});
    endtask

    task automatic send_frame(int nbody);
        if ($urandom_range(0, 7) == 0)
            send_item(KIND_OPEN, rand_word(), rand_word(), rand_byte());
        send_item(KIND_OPEN, rand_word(), rand_word(), rand_byte());
        for (int i = 0; i < nbody; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(KIND_UNUSED, rand_word(), rand_word(), rand_byte());
            if (i == nbody - 1 && $urandom_range(0, 3) == 0)
                send_item(KIND_BODY, rand_word(), rand_word(),
                          $urandom_range(0, 1) ? ESC_FLAG : ESC_BYTE, 1'b1);
            else
                send_item(KIND_BODY, rand_word(), rand_word(), rand_byte());
        end
        send_item(KIND_CLOSE, rand_word(), rand_word(), rand_byte());
    endtask

    // with no phone number everything is dropped and frame state is frozen
    task automatic test_no_phone();
        configure(48'h1357_9024_6801, 1'b0, FLAG_RESET);
        send_item(KIND_OPEN, 16'h0102, 16'h0304, 8'h00);
        send_item(KIND_BODY, 16'h0000, 16'h0000, 8'h7E);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
        send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        wait_drained();
        write_reg(REG_PHONE_SET, 48'd1);
        send_item(KIND_OPEN, 16'h0200, 16'h0005, 8'h00);
        send_item(KIND_BODY, 16'h0000, 16'h0000, 8'h11);
        wait_drained();
        write_reg(REG_PHONE_SET, 48'd0);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
        wait_drained();
        write_reg(REG_PHONE_SET, 48'd1);
        send_item(KIND_BODY, 16'h0000, 16'h0000, 8'h22);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
    endtask

    task automatic test_directed();
        configure(48'h7E7D_1234_7D7E, 1'b1, FLAG_RESET);
        send_item(KIND_BODY, 16'h0000, 16'h0000, 8'h55);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
        send_item(KIND_UNUSED, 16'h0000, 16'h0000, 8'h00);
        send_item(KIND_OPEN, 16'h7E7D, 16'h0000, 8'h00);
        send_item(KIND_BODY, 16'h0000, 16'h0000, 8'h00);
        send_item(KIND_BODY, 16'h0000, 16'h0000, 8'hFF);
        send_item(KIND_BODY, 16'h0000, 16'h0000, ESC_FLAG);
        send_item(KIND_BODY, 16'h0000, 16'h0000, ESC_BYTE);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
        // open inside a frame abandons it; checksum steered to the flag value
        send_item(KIND_OPEN, 16'hFFFF, 16'hFFFF, 8'h00);
        send_item(KIND_BODY, 16'h0000, 16'h0000, 8'hA5);
        send_item(KIND_OPEN, 16'h0000, 16'h7D7E, 8'h00);
        send_item(KIND_BODY, 16'h0000, 16'h0000, ESC_FLAG, 1'b1);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
        send_item(KIND_OPEN, 16'h1234, 16'h5678, 8'h00);
        send_item(KIND_BODY, 16'h0000, 16'h0000, ESC_BYTE, 1'b1);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
        send_item(KIND_OPEN, 16'h8001, 16'h4002, 8'h00);
        send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
    endtask

    // flag byte is sent raw whatever its value
    task automatic test_flag_values();
        configure(48'h0, 1'b1, 8'h00);
        send_frame(2);
        configure(48'hFFFF_FFFF_FFFF, 1'b1, 8'hFF);
        send_frame(2);
        configure(48'h0012_3456_7890, 1'b1, ESC_BYTE);
        send_frame(2);
    endtask

    task automatic test_backpressure();
        configure(48'h0139_0000_1234, 1'b1, FLAG_RESET);
        rx_mode = 0;
        gaps_on = 1'b0;
        hold_cycles = 300;
        repeat (6) send_frame(3);
        wait_drained();
    endtask

    // each close advances the sequence number carried in the next header
    task automatic test_seq_advance();
        configure(48'h0123_4567_8901, 1'b1, FLAG_RESET);
        rx_mode = 0;
        gaps_on = 1'b0;
        repeat (4)
        begin
            send_item(KIND_OPEN, 16'($urandom), 16'($urandom), 8'h00);
            send_item(KIND_CLOSE, 16'h0000, 16'h0000, 8'h00);
        end
    endtask

    task automatic run_phase(int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_byte());
            else
                send_frame($urandom_range(0, 6));
        end
    endtask

    task automatic test_random();
        configure({16'($urandom), 32'($urandom)}, 1'b1, FLAG_RESET);
        rx_mode = 0;
        gaps_on = 1'b0;
        run_phase(70);
        configure(48'hFFFF_FFFF_FFFF, 1'b1, 8'hFF);
        rx_mode = 1;
        gaps_on = 1'b1;
        run_phase(70);
        configure(48'h0, 1'b1, 8'h00);
        rx_mode = 2;
        run_phase(70);
        configure({16'($urandom), 32'($urandom)}, 1'b1, 8'($urandom_range(0, 255)));
        rx_mode = 3;
        stall_pat = 8'($urandom_range(1, 255));
        run_phase(70);
    endtask

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_OPEN;
        item_ch.msg_id = '0;
        item_ch.msg_props = '0;
        item_ch.body_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_PHONE_BCD;
        cfg_ch.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_no_phone();
        test_directed();
        test_flag_values();
        test_backpressure();
        test_seq_advance();
        test_random();
        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
